[hdl/playfair_cipher_stream_assert.svh]
// Assertion macros for the playfair cipher stream RTL.
// Expects the caller to name the clock and the synchronous reset.
`ifndef PLAYFAIR_CIPHER_STREAM_ASSERT_SVH
`define PLAYFAIR_CIPHER_STREAM_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PLF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/plf_pkg.sv]
// Shared types, constants and helper functions of the playfair cipher stream.
// No dependencies; every other RTL file except plf_ram imports this package.
`default_nettype none

package plf_pkg;

  localparam int LETTER_W = 5;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [4:0]          cell_t;
  typedef logic [2:0]          coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_Z = 5'd25;

  localparam int SIDE     = 5;
  localparam int CELLS    = SIDE * SIDE;
  localparam int ALPHABET = 26;
  localparam int KEY_MAX  = 25;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_SHIFT  = 3;

  typedef enum logic [1:0] {
    REG_KEY_LENGTH = 2'd0,
    REG_KEY_A      = 2'd1,
    REG_KEY_B      = 2'd2,
    REG_KEY_C      = 2'd3
  } cfg_reg_t;

  // One pair to encrypt; twin expands into (first,X) then (first,X) with last set.
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
    logic    twin;
  } pair_job_t;

  typedef struct packed {
    logic    sq_we;
    cell_t   sq_addr;
    letter_t sq_data;
    logic    pl_we;
    letter_t pl_addr;
    cell_t   pl_data;
  } table_wr_t;

  typedef struct packed {
    letter_t c1;
    letter_t c2;
    logic    last;
  } cipher_pair_t;

  function automatic letter_t fold_letter(letter_t l);
    letter_t f;
    f = (l > LETTER_Z) ? LETTER_Z : l;
    if (f == LETTER_J) f = LETTER_I;
    return f;
  endfunction

  function automatic coord_t place_row(cell_t p);
    if (p < 5'(SIDE)) return 3'd0;
    if (p < 5'(2 * SIDE)) return 3'd1;
    if (p < 5'(3 * SIDE)) return 3'd2;
    if (p < 5'(4 * SIDE)) return 3'd3;
    return 3'd4;
  endfunction

  function automatic coord_t place_col(cell_t p);
    cell_t base;
    base = 5'(place_row(p)) * 5'(SIDE);
    return 3'(p - base);
  endfunction

  function automatic cell_t cell_at(coord_t r, coord_t c);
    return 5'(r) * 5'(SIDE) + 5'(c);
  endfunction

  function automatic coord_t wrap_inc(coord_t v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

`default_nettype wire

[hdl/playfair_cipher_stream.sv]
// Playfair cipher stream: top level joining key schedule, front end, job queue,
// back end and the two table RAMs. Depends on plf_pkg, all plf_ modules and the assert header.
//
// Plaintext letters are taken one per cycle while plain_stall is low and paired;
// each pair leaves as two cipher letters, one per cycle, so while cipher_stall is low
// the cipher port sets a sustained rate of one letter per cycle (a doubled letter adds
// an X and thus one extra output pair). From acceptance of its second letter a pair
// passes the job queue, place-table read, square read and then the output buffer. After
// reset and after every register write the square is rebuilt, one keyword or alphabet
// letter per cycle; plain_stall stays high meanwhile.
`default_nettype none
`include "playfair_cipher_stream_assert.svh"

module playfair_cipher_stream #(
  parameter int QUEUE_DEPTH = plf_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = plf_pkg::OUT_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [plf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [plf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [plf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  input  wire plf_pkg::letter_t               plain_letter,
  input  wire logic                           message_end,
  input  wire logic                           plain_valid,
  output logic                                plain_stall,
  output plf_pkg::letter_t                    cipher_letter,
  output logic                                final_letter,
  output logic                                cipher_valid,
  input  wire logic                           cipher_stall
);
  import plf_pkg::*;

  table_wr_t table_wr;
  logic      build_busy;
  logic      q_push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  pair_job_t q_job_in;
  pair_job_t q_job_out;
  letter_t   place_raddr_a;
  letter_t   place_raddr_b;
  cell_t     place_rdata_a;
  cell_t     place_rdata_b;
  cell_t     sq_raddr_a;
  cell_t     sq_raddr_b;
  letter_t   sq_rdata_a;
  letter_t   sq_rdata_b;

  plf_keysched u_keysched (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .table_wr   (table_wr),
    .build_busy (build_busy)
  );

  plf_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (CELLS)
  ) u_square_ram (
    .clk     (clk),
    .we      (table_wr.sq_we),
    .waddr   (table_wr.sq_addr),
    .wdata   (table_wr.sq_data),
    .raddr_a (sq_raddr_a),
    .raddr_b (sq_raddr_b),
    .rdata_a (sq_rdata_a),
    .rdata_b (sq_rdata_b)
  );

  plf_ram #(
    .WIDTH (5),
    .DEPTH (ALPHABET)
  ) u_place_ram (
    .clk     (clk),
    .we      (table_wr.pl_we),
    .waddr   (table_wr.pl_addr),
    .wdata   (table_wr.pl_data),
    .raddr_a (place_raddr_a),
    .raddr_b (place_raddr_b),
    .rdata_a (place_rdata_a),
    .rdata_b (place_rdata_b)
  );

  plf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .plain_letter (plain_letter),
    .message_end  (message_end),
    .plain_valid  (plain_valid),
    .plain_stall  (plain_stall),
    .build_busy   (build_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job_in)
  );

  plf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (q_job_in),
    .pop     (q_pop),
    .job_out (q_job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  plf_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (~q_empty),
    .job           (q_job_out),
    .job_pop       (q_pop),
    .place_raddr_a (place_raddr_a),
    .place_raddr_b (place_raddr_b),
    .place_rdata_a (place_rdata_a),
    .place_rdata_b (place_rdata_b),
    .sq_raddr_a    (sq_raddr_a),
    .sq_raddr_b    (sq_raddr_b),
    .sq_rdata_a    (sq_rdata_a),
    .sq_rdata_b    (sq_rdata_b),
    .cipher_letter (cipher_letter),
    .final_letter  (final_letter),
    .cipher_valid  (cipher_valid),
    .cipher_stall  (cipher_stall)
  );

  `PLF_ASSERT_IMPLIES(a_queue_room, clk, rst, q_push, !q_full, "pair job pushed into a full queue")
  `PLF_ASSERT_IMPLIES(a_cipher_range, clk, rst, cipher_valid, (cipher_letter != LETTER_J) && (cipher_letter <= LETTER_Z), "cipher letter outside the square alphabet")
  `PLF_ASSERT_NEXT(a_cfg_rebuild, clk, rst, psel && penable && pwrite, plain_stall, "register write did not hold off input for the rebuild")

endmodule

`default_nettype wire

[hdl/plf_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module plf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hdl/plf_keysched.sv]
// Key registers behind the APB port and the sequencer that rebuilds the square
// and the letter-place table. Depends on plf_pkg.
`default_nettype none

module plf_keysched (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [plf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [plf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [plf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output plf_pkg::table_wr_t                   table_wr,
  output logic                                 build_busy
);
  import plf_pkg::*;

  localparam int STEPS  = KEY_MAX + ALPHABET;
  localparam int STEP_W = $clog2(STEPS);
  localparam int KEY_W  = KEY_MAX * LETTER_W;
  localparam int BIT_W  = $clog2(KEY_W);

  logic [4:0]  key_length;
  logic [49:0] key_letters_a;
  logic [49:0] key_letters_b;
  logic [24:0] key_letters_c;

  logic                wr_en;
  cfg_reg_t            reg_sel;
  logic [STEP_W-1:0]   step;
  cell_t               fill;
  logic [ALPHABET-1:0] used;

  logic [KEY_W-1:0] key_all;
  logic [BIT_W-1:0] key_bit;
  letter_t          key_raw;
  logic [4:0]       eff_len;
  letter_t          alpha;
  letter_t          cand;
  logic             cand_ok;
  logic             take;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_t'(paddr[REG_SHIFT +: 2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length    <= '0;
      key_letters_a <= '0;
      key_letters_b <= '0;
      key_letters_c <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_KEY_LENGTH: key_length    <= pwdata[4:0];
        REG_KEY_A:      key_letters_a <= pwdata[49:0];
        REG_KEY_B:      key_letters_b <= pwdata[49:0];
        REG_KEY_C:      key_letters_c <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_LENGTH: prdata = APB_DATA_W'(key_length);
      REG_KEY_A:      prdata = APB_DATA_W'(key_letters_a);
      REG_KEY_B:      prdata = APB_DATA_W'(key_letters_b);
      REG_KEY_C:      prdata = APB_DATA_W'(key_letters_c);
      default:        prdata = '0;
    endcase
  end

  // Keyword pass for the first KEY_MAX steps, then one alphabet letter a step.
  always_comb begin
    key_all = {key_letters_c, key_letters_b, key_letters_a};
    key_bit = BIT_W'(5'(step)) * BIT_W'(LETTER_W);
    key_raw = key_all[key_bit +: LETTER_W];
    eff_len = (key_length > 5'(KEY_MAX)) ? 5'(KEY_MAX) : key_length;
    alpha   = 5'(step - STEP_W'(KEY_MAX));
    if (step < STEP_W'(KEY_MAX)) begin
      cand    = fold_letter(key_raw);
      cand_ok = (5'(step) < eff_len) && (key_raw <= LETTER_Z);
    end else begin
      cand    = alpha;
      cand_ok = (alpha != LETTER_J) && (fill < 5'(CELLS));
    end
    take = build_busy && cand_ok && !used[cand];
  end

  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      build_busy <= 1'b1;
      step       <= '0;
      fill       <= '0;
      used       <= '0;
    end else if (build_busy) begin
      if (take) begin
        used[cand] <= 1'b1;
        fill       <= fill + 5'd1;
      end
      if (step == STEP_W'(STEPS - 1)) begin
        build_busy <= 1'b0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_comb begin
    table_wr.sq_we   = take;
    table_wr.sq_addr = fill;
    table_wr.sq_data = cand;
    table_wr.pl_we   = take;
    table_wr.pl_addr = cand;
    table_wr.pl_data = fill;
  end

endmodule

`default_nettype wire

[hdl/plf_front.sv]
// Front end: accepts plaintext letters, folds them and forms pair jobs,
// holding the open letter of a pair. Depends on plf_pkg.
`default_nettype none

module plf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire plf_pkg::letter_t  plain_letter,
  input  wire logic              message_end,
  input  wire logic              plain_valid,
  output logic                   plain_stall,
  input  wire logic              build_busy,
  input  wire logic              q_full,
  output logic                   q_push,
  output plf_pkg::pair_job_t     q_job
);
  import plf_pkg::*;

  letter_t held_letter;
  logic    held_valid;
  letter_t held_letter_next;
  logic    held_valid_next;
  letter_t letter;
  logic    accept;
  logic    push_req;

  assign plain_stall = build_busy | q_full;
  assign accept      = plain_valid & ~plain_stall;
  assign letter      = fold_letter(plain_letter);
  assign q_push      = accept & push_req;

  always_comb begin
    push_req         = 1'b0;
    q_job.first      = held_letter;
    q_job.second     = letter;
    q_job.last       = message_end;
    q_job.twin       = 1'b0;
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    if (held_valid) begin
      push_req = 1'b1;
      if (held_letter == letter) begin
        // doubled letter: pad with X, the second letter opens the next pair
        q_job.second     = LETTER_X;
        q_job.twin       = message_end;
        held_letter_next = letter;
      end else begin
        held_valid_next = 1'b0;
      end
    end else if (message_end) begin
      push_req     = 1'b1;
      q_job.first  = letter;
      q_job.second = LETTER_X;
    end else begin
      held_letter_next = letter;
      held_valid_next  = 1'b1;
    end
    if (message_end) begin
      held_letter_next = '0;
      held_valid_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
    end else if (accept) begin
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
    end
  end

endmodule

`default_nettype wire

[hdl/plf_queue.sv]
// Short FIFO of pair jobs between the front end and the encryption back end.
// Depends on plf_pkg.
`default_nettype none

module plf_queue #(
  parameter int DEPTH = plf_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire plf_pkg::pair_job_t job_in,
  input  wire logic               pop,
  output plf_pkg::pair_job_t      job_out,
  output logic                    full,
  output logic                    empty
);
  import plf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pair_job_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/plf_back.sv]
// Back end: issues pairs, looks up letter places, applies the row, column or
// rectangle rule, reads the square and streams cipher letters. Depends on plf_pkg.
`default_nettype none

module plf_back #(
  parameter int OUT_DEPTH = plf_pkg::OUT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  input  wire plf_pkg::pair_job_t job,
  output logic                    job_pop,
  output plf_pkg::letter_t        place_raddr_a,
  output plf_pkg::letter_t        place_raddr_b,
  input  wire plf_pkg::cell_t     place_rdata_a,
  input  wire plf_pkg::cell_t     place_rdata_b,
  output plf_pkg::cell_t          sq_raddr_a,
  output plf_pkg::cell_t          sq_raddr_b,
  input  wire plf_pkg::letter_t   sq_rdata_a,
  input  wire plf_pkg::letter_t   sq_rdata_b,
  output plf_pkg::letter_t        cipher_letter,
  output logic                    final_letter,
  output logic                    cipher_valid,
  input  wire logic               cipher_stall
);
  import plf_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic twin_done;
  logic issue;
  logic issue_last;
  logic v1;
  logic last1;
  logic v2;
  logic last2;
  logic [SUM_W-1:0] in_flight;

  coord_t r1;
  coord_t c1;
  coord_t r2;
  coord_t c2;

  cipher_pair_t     opairs [OUT_DEPTH];
  cipher_pair_t     head;
  logic [PTR_W-1:0] o_wr;
  logic [PTR_W-1:0] o_rd;
  logic [CNT_W-1:0] o_count;
  logic             half;
  logic             out_take;
  logic             pair_pop;

  // Issue only when the output buffer has room for everything in flight.
  assign in_flight  = SUM_W'(v1) + SUM_W'(v2) + SUM_W'(o_count);
  assign issue      = job_valid && (in_flight < SUM_W'(OUT_DEPTH));
  assign issue_last = job.twin ? twin_done : job.last;
  assign job_pop    = issue && (!job.twin || twin_done);

  assign place_raddr_a = job.first;
  assign place_raddr_b = job.second;

  always_comb begin
    r1 = place_row(place_rdata_a);
    c1 = place_col(place_rdata_a);
    r2 = place_row(place_rdata_b);
    c2 = place_col(place_rdata_b);
    if (r1 == r2) begin
      sq_raddr_a = cell_at(r1, wrap_inc(c1));
      sq_raddr_b = cell_at(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      sq_raddr_a = cell_at(wrap_inc(r1), c1);
      sq_raddr_b = cell_at(wrap_inc(r2), c2);
    end else begin
      sq_raddr_a = cell_at(r1, c2);
      sq_raddr_b = cell_at(r2, c1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      twin_done <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (job_pop) begin
        twin_done <= 1'b0;
      end else if (issue) begin
        twin_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    last1 <= issue_last;
    last2 <= last1;
  end

  // Output buffer of finished pairs, drained one letter per transaction.
  assign head          = opairs[o_rd];
  assign cipher_valid  = (o_count != '0);
  assign cipher_letter = half ? head.c2 : head.c1;
  assign final_letter  = half & head.last;
  assign out_take      = cipher_valid & ~cipher_stall;
  assign pair_pop      = out_take & half;

  always_ff @(posedge clk) begin
    if (v2) begin
      opairs[o_wr] <= '{c1: sq_rdata_a, c2: sq_rdata_b, last: last2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
      half    <= 1'b0;
    end else begin
      if (v2) begin
        o_wr <= (o_wr == PTR_W'(OUT_DEPTH - 1)) ? '0 : o_wr + PTR_W'(1);
      end
      if (pair_pop) begin
        o_rd <= (o_rd == PTR_W'(OUT_DEPTH - 1)) ? '0 : o_rd + PTR_W'(1);
      end
      if (out_take) begin
        half <= ~half;
      end
      case ({v2, pair_pop})
        2'b10:   o_count <= o_count + CNT_W'(1);
        2'b01:   o_count <= o_count - CNT_W'(1);
        default: o_count <= o_count;
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_playfair_cipher_stream.sv]
// Self-checking testbench for playfair_cipher_stream: drives letter transactions and
// APB key writes, predicts or lists every expected cipher letter and compares in order.
// Depends on plf_pkg and the playfair_cipher_stream RTL.
`timescale 1ns / 100ps

module tb_playfair_cipher_stream;
  import plf_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 120;

  localparam letter_t LT_A = 5'd0;
  localparam letter_t LT_B = 5'd1;
  localparam letter_t LT_C = 5'd2;
  localparam letter_t LT_D = 5'd3;
  localparam letter_t LT_E = 5'd4;
  localparam letter_t LT_F = 5'd5;
  localparam letter_t LT_H = 5'd7;
  localparam letter_t LT_K = 5'd10;
  localparam letter_t LT_L = 5'd11;
  localparam letter_t LT_V = 5'd21;
  localparam letter_t LT_W = 5'd22;
  localparam letter_t LT_Y = 5'd24;
  localparam letter_t LT_TOP = 5'd31;

  typedef struct packed {
    letter_t letter;
    logic    fin;
  } cipher_item_t;

  // typed = 1: results listed in the row; typed = 0: results from the predictor
  typedef struct packed {
    letter_t         plain;
    logic            fin;
    logic            typed;
    logic [2:0]      count;
    letter_t [0:3]   res;
    logic [0:3]      res_fin;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  letter_t plain_letter = '0;
  logic message_end = 1'b0;
  logic plain_valid = 1'b0;
  logic plain_stall;
  letter_t cipher_letter;
  logic final_letter;
  logic cipher_valid;
  logic cipher_stall = 1'b1;

  playfair_cipher_stream dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .plain_letter(plain_letter), .message_end(message_end),
    .plain_valid(plain_valid), .plain_stall(plain_stall),
    .cipher_letter(cipher_letter), .final_letter(final_letter),
    .cipher_valid(cipher_valid), .cipher_stall(cipher_stall)
  );

  always #4 clk = ~clk;

  // Key registers and tables of the predicted square
  logic [4:0]  key_len_r = '0;
  logic [49:0] key_a_r = '0;
  logic [49:0] key_b_r = '0;
  logic [24:0] key_c_r = '0;
  letter_t     square_tbl [0:CELLS-1];
  logic [5:0]  place_tbl [0:ALPHABET-1];
  letter_t     held_letter = '0;
  logic        held_valid = 1'b0;

  // Results of the latest accepted letter
  letter_t     pend_letter [0:3];
  logic        pend_fin [0:3];
  int          pend_count;

  cipher_item_t cipher_due_q [$];
  int mismatch_cnt = 0;
  int send_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  dir_row_t dir_rows [0:19] = '{
    '{LT_A,     1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LT_B,     1'b0, 1'b1, 3'd2, {LT_B, LT_C, LT_A, LT_A}, 4'b0000},
    '{LETTER_Z, 1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LT_V,     1'b0, 1'b1, 3'd2, {LT_V, LT_W, LT_A, LT_A}, 4'b0000},
    '{LETTER_J, 1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LETTER_I, 1'b0, 1'b1, 3'd2, {LT_H, LT_Y, LT_A, LT_A}, 4'b0000},
    '{LT_TOP,   1'b1, 1'b1, 3'd2, {LT_K, LT_Y, LT_A, LT_A}, 4'b0100},
    '{LETTER_X, 1'b1, 1'b1, 3'd2, {LT_Y, LT_Y, LT_A, LT_A}, 4'b0100},
    '{LT_E,     1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LT_E,     1'b1, 1'b1, 3'd4, {LT_C, LETTER_Z, LT_C, LETTER_Z}, 4'b0001},
    '{LT_A,     1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LT_F,     1'b1, 1'b1, 3'd2, {LT_F, LT_L, LT_A, LT_A}, 4'b0100},
    '{LT_Y,     1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LT_E,     1'b1, 1'b1, 3'd2, {LETTER_Z, LT_D, LT_A, LT_A}, 4'b0100},
    '{LT_V,     1'b0, 1'b1, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LT_A,     1'b1, 1'b1, 3'd2, {LT_A, LT_F, LT_A, LT_A}, 4'b0100},
    '{5'd27,    1'b0, 1'b0, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LETTER_Z, 1'b0, 1'b0, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{LETTER_J, 1'b1, 1'b0, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000},
    '{5'd30,    1'b1, 1'b0, 3'd0, {LT_A, LT_A, LT_A, LT_A}, 4'b0000}
  };

  function automatic void rebuild_square();
    logic [124:0] key_bits;
    logic [25:0]  taken;
    int           len;
    int           n;
    letter_t      l;
    key_bits = {key_c_r, key_b_r, key_a_r};
    taken = '0;
    n = 0;
    len = (key_len_r > 5'(KEY_MAX)) ? KEY_MAX : int'(key_len_r);
    for (int k = 0; k < len; k++) begin
      l = key_bits[5*k +: 5];
      if (l <= LETTER_Z) begin
        if (l == LETTER_J) l = LETTER_I;
        if (!taken[l]) begin
          taken[l] = 1'b1;
          square_tbl[n] = l;
          n++;
        end
      end
    end
    for (int c = 0; c < ALPHABET && n < CELLS; c++) begin
      if (c != int'(LETTER_J) && !taken[c]) begin
        taken[c] = 1'b1;
        square_tbl[n] = letter_t'(c);
        n++;
      end
    end
    for (int k = 0; k < CELLS; k++) place_tbl[square_tbl[k]] = 6'(k);
    place_tbl[LETTER_J] = place_tbl[LETTER_I];
  endfunction

  function automatic void encipher_pair(letter_t a, letter_t b, logic last);
    int p1, p2, r1, c1, r2, c2, o1, o2;
    p1 = int'(place_tbl[a]);
    p2 = int'(place_tbl[b]);
    r1 = p1 / SIDE;
    c1 = p1 % SIDE;
    r2 = p2 / SIDE;
    c2 = p2 % SIDE;
    if (r1 == r2) begin
      o1 = r1 * SIDE + (c1 + 1) % SIDE;
      o2 = r2 * SIDE + (c2 + 1) % SIDE;
    end else if (c1 == c2) begin
      o1 = ((r1 + 1) % SIDE) * SIDE + c1;
      o2 = ((r2 + 1) % SIDE) * SIDE + c2;
    end else begin
      o1 = r1 * SIDE + c2;
      o2 = r2 * SIDE + c1;
    end
    pend_letter[pend_count] = square_tbl[o1];
    pend_fin[pend_count] = 1'b0;
    pend_letter[pend_count + 1] = square_tbl[o2];
    pend_fin[pend_count + 1] = last;
    pend_count += 2;
  endfunction

  function automatic void encipher_step(letter_t raw, logic msg_end);
    letter_t l;
    l = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (l == LETTER_J) l = LETTER_I;
    pend_count = 0;
    if (held_valid) begin
      if (held_letter == l) begin
        // doubled letter: pad with X, the second letter opens the next pair
        encipher_pair(held_letter, LETTER_X, 1'b0);
        if (msg_end) encipher_pair(l, LETTER_X, 1'b1);
        else held_letter = l;
      end else begin
        encipher_pair(held_letter, l, msg_end);
        held_valid = 1'b0;
      end
    end else if (msg_end) begin
      encipher_pair(l, LETTER_X, 1'b1);
    end else begin
      held_letter = l;
      held_valid = 1'b1;
    end
    if (msg_end) begin
      held_valid = 1'b0;
      held_letter = '0;
    end
  endfunction

  function automatic void push_pending();
    for (int j = 0; j < pend_count; j++)
      cipher_due_q.push_back('{letter: pend_letter[j], fin: pend_fin[j]});
  endfunction

  function automatic logic [124:0] pack_key(string s);
    logic [124:0] w;
    w = '0;
    for (int k = 0; k < s.len() && k < KEY_MAX; k++) w[5*k +: 5] = 5'(s[k] - 8'd65);
    return w;
  endfunction

  function automatic letter_t next_plain(letter_t prev);
    int r;
    r = $urandom_range(99);
    if (r < 20) return prev;
    if (r < 25) return LETTER_J;
    if (r < 30) return letter_t'($urandom_range(26, 31));
    if (r < 35) return LETTER_X;
    return letter_t'($urandom_range(0, 25));
  endfunction

  // Offer one letter, wait for its transaction, then run the predictor on it
  task automatic send_letter(letter_t l, logic msg_end);
    if ($urandom_range(99) < send_pct) begin
      plain_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    plain_valid <= 1'b1;
    plain_letter <= l;
    message_end <= msg_end;
    do @(posedge clk); while (plain_stall !== 1'b0);
    encipher_step(l, msg_end);
  endtask

  task automatic apb_write(cfg_reg_t sel, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(sel) << REG_SHIFT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_KEY_LENGTH: key_len_r = value[4:0];
      REG_KEY_A:      key_a_r = value[49:0];
      REG_KEY_B:      key_b_r = value[49:0];
      REG_KEY_C:      key_c_r = value[24:0];
      default: ;
    endcase
    rebuild_square();
    @(posedge clk);
  endtask

  // Write all key registers once the stream has drained
  task automatic load_key(logic [4:0] len, logic [63:0] a, logic [63:0] b, logic [63:0] c);
    while (cipher_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_KEY_LENGTH, 64'(len));
    apb_write(REG_KEY_A, a);
    apb_write(REG_KEY_B, b);
    apb_write(REG_KEY_C, c);
  endtask

  task automatic run_stream(int count, int s_pct, int r_pct);
    letter_t l;
    logic    msg_end;
    l = LT_A;
    send_pct = s_pct;
    stall_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      l = next_plain(l);
      msg_end = (i == count - 1) || ($urandom_range(5) == 0);
      send_letter(l, msg_end);
      push_pending();
    end
    plain_valid <= 1'b0;
  endtask

  // Receiver: check each cipher transaction, then pick the next stall
  always @(posedge clk) begin
    cipher_item_t due;
    if (!rst && cipher_valid === 1'b1 && cipher_stall === 1'b0) begin
      if (cipher_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected cipher letter %0d final %0b", cipher_letter, final_letter);
      end else begin
        due = cipher_due_q.pop_front();
        if (cipher_letter !== due.letter || final_letter !== due.fin) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: expected letter %0d final %0b, got letter %0d final %0b",
                     due.letter, due.fin, cipher_letter, final_letter);
        end
      end
    end
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      cipher_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      cipher_stall <= 1'b1;
    end else begin
      cipher_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    logic [124:0] key_bits;
    rebuild_square();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Alphabet square after reset
    for (int i = 0; i < 20; i++) begin
      send_letter(dir_rows[i].plain, dir_rows[i].fin);
      if (dir_rows[i].typed) begin
        for (int j = 0; j < dir_rows[i].count; j++)
          cipher_due_q.push_back('{letter: dir_rows[i].res[j], fin: dir_rows[i].res_fin[j]});
      end else begin
        push_pending();
      end
    end
    plain_valid <= 1'b0;

    key_bits = pack_key("PLAYFAIREXAMPLE");
    load_key(5'd15, 64'(key_bits[49:0]), 64'(key_bits[99:50]), 64'(key_bits[124:100]));
    run_stream(50, 0, 0);

    // oversized length, raw codes including the unused ones above Z
    load_key(5'd31, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_stream(50, 75, 0);

    for (int k = 0; k < KEY_MAX; k++) key_bits[5*k +: 5] = 5'($urandom_range(0, 25));
    load_key(5'(KEY_MAX), 64'(key_bits[49:0]), 64'(key_bits[99:50]),
             64'(key_bits[124:100]));
    hold_req = 1'b1;
    run_stream(50, 0, 75);

    load_key(5'd31, '1, '1, '1);
    run_stream(50, 33, 33);

    key_bits = pack_key("JIJIHELLOJWORLDQQQZZZAAAA");
    load_key(5'($urandom_range(1, 24)), 64'(key_bits[49:0]), 64'(key_bits[99:50]),
             64'(key_bits[124:100]));
    run_stream(50, 0, 0);

    stall_pct = 0;
    while (cipher_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[playfair_cipher_stream.f]
+incdir+hdl
hdl/plf_pkg.sv
hdl/plf_ram.sv
hdl/plf_keysched.sv
hdl/plf_front.sv
hdl/plf_queue.sv
hdl/plf_back.sv
hdl/playfair_cipher_stream.sv
tb/sv/tb_playfair_cipher_stream.sv
